>>> src/rih_pkg.sv
// ----------------------------------------------------------------------------
// rih_pkg
// Shared types and constants for the recent id history block: payload
// words, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rih_pkg;

    // field widths fixed by the interface
    localparam int unsigned ID_W  = 32;
    localparam int unsigned CNT_W = 5;
    localparam int unsigned CFG_W = 5;

    // action codes
    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    // limit register value after reset
    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 5'd15;

    // input word
    typedef struct packed {
        logic            action;
        logic [ID_W-1:0] obj_id;
    } in_item_t;

    // result word
    typedef struct packed {
        logic             found;
        logic             appended;
        logic [CNT_W-1:0] entry_count;
    } out_item_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_NEWEST_RD,
        ST_NEWEST_CMP,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_APPEND,
        ST_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted word
        logic rd_newest;  // address the newest entry
        logic drop;       // retire the oldest entry
        logic set_found;  // mark id as present
        logic next_idx;   // advance the scan index
        logic append;     // write id as newest entry
        logic emit;       // load the result register
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic action;
        logic count_zero;
        logic rd_match;
        logic at_limit;
        logic scan_done;
        logic room;
        logic out_free;
    } ctrl_stat_t;

endpackage

>>> src/rih_ram.sv
// ----------------------------------------------------------------------------
// rih_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rih_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> src/rih_ctrl.sv
// ----------------------------------------------------------------------------
// rih_ctrl
// Sequencer for the history: decides push or query, checks the newest
// entry, drops the oldest, scans for the id and appends it.
// ----------------------------------------------------------------------------
module rih_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rih_pkg::ctrl_stat_t stat,
    output rih_pkg::ctrl_cmd_t  cmd
);

    rih_pkg::state_t state_reg;
    rih_pkg::state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rih_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rih_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = rih_pkg::ST_DISPATCH;
                end
            end
            rih_pkg::ST_DISPATCH: begin
                if (stat.action == rih_pkg::ACTION_QUERY) begin
                    state_next = rih_pkg::ST_SCAN_RD;
                end else if (stat.count_zero) begin
                    state_next = rih_pkg::ST_APPEND;
                end else begin
                    state_next = rih_pkg::ST_NEWEST_RD;
                end
            end
            rih_pkg::ST_NEWEST_RD: begin
                state_next = rih_pkg::ST_NEWEST_CMP;
            end
            rih_pkg::ST_NEWEST_CMP: begin
                if (stat.rd_match) begin
                    state_next = rih_pkg::ST_RESULT;
                end else begin
                    state_next = rih_pkg::ST_SCAN_RD;
                end
            end
            rih_pkg::ST_SCAN_RD: begin
                if (!stat.scan_done) begin
                    state_next = rih_pkg::ST_SCAN_CMP;
                end else if (stat.action == rih_pkg::ACTION_QUERY) begin
                    state_next = rih_pkg::ST_RESULT;
                end else begin
                    state_next = rih_pkg::ST_APPEND;
                end
            end
            rih_pkg::ST_SCAN_CMP: begin
                if (stat.rd_match) begin
                    state_next = rih_pkg::ST_RESULT;
                end else begin
                    state_next = rih_pkg::ST_SCAN_RD;
                end
            end
            rih_pkg::ST_APPEND: begin
                state_next = rih_pkg::ST_RESULT;
            end
            rih_pkg::ST_RESULT: begin
                if (stat.out_free) begin
                    state_next = rih_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rih_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rih_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            rih_pkg::ST_NEWEST_RD: begin
                cmd.rd_newest = 1'b1;
            end
            rih_pkg::ST_NEWEST_CMP: begin
                cmd.set_found = stat.rd_match;
                cmd.drop      = !stat.rd_match && stat.at_limit;
            end
            rih_pkg::ST_SCAN_CMP: begin
                cmd.set_found = stat.rd_match;
                cmd.next_idx  = !stat.rd_match;
            end
            rih_pkg::ST_APPEND: begin
                cmd.append = stat.room;
            end
            rih_pkg::ST_RESULT: begin
                cmd.emit = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/rih_datapath.sv
// ----------------------------------------------------------------------------
// rih_datapath
// Circular history buffer in RAM with head pointer and count, the limit
// register, the scan index and the result register.
// ----------------------------------------------------------------------------
module rih_datapath #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rih_pkg::in_item_t                 s_data,
    output rih_pkg::out_item_t                m_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              cfg_valid,
    input  logic [rih_pkg::CFG_W-1:0]         cfg_data,
    input  rih_pkg::ctrl_cmd_t                cmd,
    output rih_pkg::ctrl_stat_t               stat
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned SW = CW + 1;
    localparam int unsigned LW = CW + rih_pkg::CFG_W;

    logic [rih_pkg::ID_W-1:0]  id_reg;
    logic                      action_reg;
    logic [AW-1:0]             head_reg;
    logic [AW-1:0]             head_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic [CW-1:0]             idx_reg;
    logic                      found_reg;
    logic                      appended_reg;
    logic [rih_pkg::CFG_W-1:0] max_entries_reg;
    logic                      m_valid_reg;
    rih_pkg::out_item_t        m_data_reg;

    logic [LW-1:0]             max_ext;
    logic [LW-1:0]             limit;
    logic [LW-1:0]             count_ext;
    logic [CW+rih_pkg::CNT_W-1:0] count_out_ext;
    logic [AW-1:0]             raddr;
    logic [AW-1:0]             waddr;
    logic [rih_pkg::ID_W-1:0]  rdata;

    // offset from the oldest entry to a ram address, wrapping at DEPTH
    function automatic logic [AW-1:0] wrap_addr(input logic [AW-1:0] base,
                                                input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // entry storage
    rih_ram #(
        .WIDTH(rih_pkg::ID_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (cmd.append),
        .waddr(waddr),
        .wdata(id_reg),
        .raddr(raddr),
        .rdata(rdata)
    );

    // ram addressing
    assign raddr = cmd.rd_newest ? wrap_addr(head_reg, CW'(count_reg - CW'(1)))
                                 : wrap_addr(head_reg, idx_reg);
    assign waddr = wrap_addr(head_reg, count_reg);

    // effective limit, clamped to 1..DEPTH
    assign max_ext   = LW'(max_entries_reg);
    assign count_ext = LW'(count_reg);
    always_comb begin
        if (max_ext == '0) begin
            limit = LW'(1);
        end else if (max_ext > LW'(DEPTH)) begin
            limit = LW'(DEPTH);
        end else begin
            limit = max_ext;
        end
    end

    // status to the controller
    assign stat.action     = action_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.rd_match   = (rdata == id_reg);
    assign stat.at_limit   = (count_ext >= limit);
    assign stat.scan_done  = (idx_reg == count_reg);
    assign stat.room       = (count_reg < CW'(DEPTH));
    assign stat.out_free   = !m_valid_reg || m_ready;

    // head and count updates
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.drop) begin
            head_next  = (head_reg == AW'(DEPTH - 1)) ? '0 : AW'(head_reg + AW'(1));
            count_next = CW'(count_reg - CW'(1));
        end else if (cmd.append) begin
            count_next = CW'(count_reg + CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= rih_pkg::MAX_ENTRIES_RESET;
        end else if (cfg_valid) begin
            max_entries_reg <= cfg_data;
        end
    end

    // per-word working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg       <= s_data.obj_id;
            action_reg   <= s_data.action;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
            appended_reg <= 1'b0;
        end else begin
            if (cmd.next_idx) begin
                idx_reg <= CW'(idx_reg + CW'(1));
            end
            if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.append) begin
                appended_reg <= 1'b1;
            end
        end
    end

    // result register
    assign count_out_ext = (CW + rih_pkg::CNT_W)'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg.found       <= found_reg;
            m_data_reg.appended    <= appended_reg;
            m_data_reg.entry_count <= count_out_ext[rih_pkg::CNT_W-1:0];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> src/recent_id_history.sv
// ----------------------------------------------------------------------------
// recent_id_history_core
// Oldest-first history of recent track ids with push and query words.
// ----------------------------------------------------------------------------
// scan: one ram read per entry scanned, each in a read state and a compare state
// throughput: one word at a time; the next word is taken once the result
//   is in the output register
// reset: synchronous, active low; history empties, limit returns to 15
module recent_id_history_core #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  rih_pkg::in_item_t         s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output rih_pkg::out_item_t        m_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [rih_pkg::CFG_W-1:0] cfg_data
);

    rih_pkg::ctrl_cmd_t  cmd;
    rih_pkg::ctrl_stat_t stat;

    // limit register is always writable
    assign cfg_ready = 1'b1;

    // sequencer
    rih_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    // storage and result path
    rih_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .m_data   (m_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> dv/recent_id_history_core_tb.sv
// ----------------------------------------------------------------------------
// recent_id_history_core_tb
// Self-checking bench for the recent id history block. Push and query words
// go in over a valid/ready channel with random gaps. Each result word is
// compared field by field against a behavioral history model kept in the
// bench. The limit register is swept across its range, extremes included,
// while the block is idle, and back-pressure phases fill the block.
// ----------------------------------------------------------------------------
module recent_id_history_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 16;
    localparam time         HALF_PERIOD = 5ns;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE      = 8;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned POOL_SIZE   = 24;

    logic                          aclk;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    rih_pkg::in_item_t             s_data;
    logic                          m_valid;
    logic                          m_ready;
    rih_pkg::out_item_t            m_data;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [rih_pkg::CFG_W-1:0]     cfg_data;

    // model of the history: oldest entry at index 0
    logic [rih_pkg::ID_W-1:0]      hist_ids [DEPTH];
    int unsigned                   hist_count = 0;
    logic [rih_pkg::CFG_W-1:0]     hist_limit = rih_pkg::MAX_ENTRIES_RESET;

    // result words still owed by the block, oldest first
    rih_pkg::out_item_t            pending_results [$];

    // ids for random pushes and queries, refreshed per phase
    logic [rih_pkg::ID_W-1:0]      id_pool [POOL_SIZE];

    int unsigned          cycle_count   = 0;
    int unsigned          error_count   = 0;
    int unsigned          words_sent    = 0;
    int unsigned          queries_sent  = 0;
    int unsigned          appends_seen  = 0;
    int unsigned          results_seen  = 0;
    int unsigned          limit_writes  = 0;
    bit                   tx_eager      = 1'b0;
    bit                   rx_eager      = 1'b0;
    int unsigned          rx_hold_len   = 0;

    recent_id_history_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // clock
    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // membership over the valid entries
    function automatic bit history_holds(logic [rih_pkg::ID_W-1:0] id);
        for (int unsigned i = 0; i < hist_count; i++) begin
            if (hist_ids[i] == id) return 1'b1;
        end
        return 1'b0;
    endfunction

    // apply one word to the model and return its result word
    function automatic rih_pkg::out_item_t history_apply(rih_pkg::in_item_t w);
        rih_pkg::out_item_t r;
        int unsigned        lim;
        r   = '0;
        lim = (hist_limit == 0) ? 1 : ((hist_limit > DEPTH) ? DEPTH : hist_limit);
        if (w.action == rih_pkg::ACTION_QUERY) begin
            r.found = history_holds(w.obj_id);
        end else if (hist_count == 0) begin
            hist_ids[0] = w.obj_id;
            hist_count  = 1;
            r.appended  = 1'b1;
        end else if (hist_ids[hist_count-1] == w.obj_id) begin
            r.found = 1'b1;
        end else begin
            // full or over the limit: retire one oldest entry
            if (hist_count >= lim) begin
                for (int unsigned i = 0; i + 1 < hist_count; i++) hist_ids[i] = hist_ids[i+1];
                hist_count--;
            end
            if (history_holds(w.obj_id)) begin
                r.found = 1'b1;
            end else if (hist_count < DEPTH) begin
                hist_ids[hist_count] = w.obj_id;
                hist_count++;
                r.appended = 1'b1;
            end
        end
        r.entry_count = hist_count[rih_pkg::CNT_W-1:0];
        return r;
    endfunction

    // idle length: mostly short, a few long
    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // send one word and record its expected result on acceptance
    task automatic send_word(input logic act, input logic [rih_pkg::ID_W-1:0] id);
        int unsigned       gap;
        rih_pkg::in_item_t w;
        w.action = act;
        w.obj_id = id;
        gap = (tx_eager || $urandom_range(0, 99) < 50) ? 0 : pick_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.insert(pending_results.size(), history_apply(w));
        words_sent++;
        if (act == rih_pkg::ACTION_QUERY) queries_sent++;
    endtask

    // random word: mostly pooled ids so hits and drops happen
    task automatic send_random_words(input int unsigned n);
        logic                     act;
        logic [rih_pkg::ID_W-1:0] id;
        int unsigned              r;
        for (int unsigned k = 0; k < n; k++) begin
            act = ($urandom_range(0, 99) < 30) ? rih_pkg::ACTION_QUERY
                                               : rih_pkg::ACTION_PUSH;
            r   = $urandom_range(0, 99);
            if (r < 10 && hist_count > 0) id = hist_ids[hist_count-1];
            else if (r < 85) id = id_pool[$urandom_range(0, POOL_SIZE-1)];
            else id = $urandom;
            send_word(act, id);
        end
    endtask

    // fresh id pool, extremes always present
    task automatic refresh_pool();
        foreach (id_pool[i]) id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
    endtask

    // sender pauses until every result is back and the block has settled
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // write the limit register while idle
    task automatic write_limit(input logic [rih_pkg::CFG_W-1:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        hist_limit = val;
        limit_writes++;
    endtask

    // empty push, newest repeat, queries, id extremes, drop then re-append
    task automatic test_directed_basics();
        send_word(rih_pkg::ACTION_PUSH, '0);
        send_word(rih_pkg::ACTION_PUSH, '0);
        send_word(rih_pkg::ACTION_QUERY, '0);
        send_word(rih_pkg::ACTION_QUERY, '1);
        send_word(rih_pkg::ACTION_PUSH, '1);
        send_word(rih_pkg::ACTION_PUSH, '0);
        for (int unsigned k = 0; k < 13; k++) begin
            send_word(rih_pkg::ACTION_PUSH, 32'h0000_0100 + k);
        end
        // history now full at the reset limit; oldest ids fall out and come back
        send_word(rih_pkg::ACTION_PUSH, '0);
        send_word(rih_pkg::ACTION_PUSH, '1);
        send_word(rih_pkg::ACTION_QUERY, '0);
    endtask

    // sweep the limit: extremes, clamped values, lowering below the count
    task automatic test_limit_sweep();
        logic [rih_pkg::CFG_W-1:0] limits [10];
        limits = '{5'd16, 5'd2, 5'd0, 5'd1, 5'd31, 5'd7,
                   5'd0, 5'd0, 5'd0, 5'd15};
        for (int i = 6; i < 9; i++) limits[i] = rih_pkg::CFG_W'($urandom_range(0, 31));
        foreach (limits[i]) begin
            write_limit(limits[i]);
            refresh_pool();
            send_random_words(120);
        end
    endtask

    // long receiver hold with the sender pushing, then a stretch with no idling
    task automatic test_back_pressure();
        write_limit(5'd16);
        refresh_pool();
        rx_hold_len = 200;
        tx_eager    = 1'b1;
        send_random_words(12);
        tx_eager    = 1'b0;
        wait_drained();
        rx_eager = 1'b1;
        tx_eager = 1'b1;
        send_random_words(100);
        rx_eager = 1'b0;
        tx_eager = 1'b0;
    endtask

    // long random run at a random limit
    task automatic test_random_mix();
        write_limit(rih_pkg::CFG_W'($urandom_range(0, 31)));
        refresh_pool();
        send_random_words(300);
    endtask

    // receiver: random stalls, long holds on request
    initial begin
        int unsigned stall;
        stall   = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_len > 0) begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end else if (stall == 0 && !rx_eager && $urandom_range(0, 99) < 25) begin
                stall = pick_len();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // check each result word against the oldest expectation
    always @(posedge aclk) begin
        rih_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: %p", m_data);
                error_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (m_data.appended) appends_seen++;
                if (m_data.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_data.found);
                    error_count++;
                end
                if (m_data.appended !== want.appended) begin
                    $error("appended: expected %0d, got %0d", want.appended, m_data.appended);
                    error_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    error_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_basics();
        test_limit_sweep();
        test_back_pressure();
        test_random_mix();

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d result words never arrived", pending_results.size());
            error_count++;
        end

        $display("sent %0d words (%0d queries), checked %0d results, %0d appends",
                 words_sent, queries_sent, results_seen, appends_seen);
        $display("covered %0d limit settings incl. 0, 1, 16, 31 and back-pressure fill",
                 limit_writes);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
